// File: hw/rtl/cidd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cidd_pkg
// Shared types, class codes and coefficients of the doubles index decoder.
// ----------------------------------------------------------------------------
package cidd_pkg;

  localparam int MAX_ORBITALS_DEF = 64;

  // configuration register indexes
  localparam logic [1:0] CFG_ELECTRON_COUNT = 2'd0;
  localparam logic [1:0] CFG_LOWEST_ACTIVE  = 2'd1;
  localparam logic [1:0] CFG_HIGHEST_ACTIVE = 2'd2;

  // configuration classes
  localparam logic [2:0] KIND_GROUND = 3'd0;
  localparam logic [2:0] KIND_AA_RR  = 3'd1;
  localparam logic [2:0] KIND_AA_RS  = 3'd2;
  localparam logic [2:0] KIND_AB_RR  = 3'd3;
  localparam logic [2:0] KIND_AB_RS_A = 3'd4;
  localparam logic [2:0] KIND_AB_RS_B = 3'd5;

  // Q2.14 coefficients
  localparam logic signed [15:0] C_ONE   = 16'sd16384;
  localparam logic signed [15:0] C_RT2   = 16'sd11585;
  localparam logic signed [15:0] C_HALF  = 16'sd8192;
  localparam logic signed [15:0] C_TWO12 = 16'sd9459;
  localparam logic signed [15:0] C_ONE12 = 16'sd4730;

  typedef struct packed {
    logic [6:0] electron_count;
    logic [5:0] lowest_active;
    logic [5:0] highest_active;
  } cfg_t;

  // work word from front to back
  typedef struct packed {
    logic [2:0]  kind;
    logic        oor;
    logic [19:0] n;
    logic [10:0] divisor;
    logic [5:0]  occ;
    logic [5:0]  la;
    logic [5:0]  omo;
    logic [5:0]  umo;
  } job_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [15:0] coefficient;
    logic [1:0]         change_count;
    logic [6:0]         first_slot;
    logic [6:0]         first_orbital;
    logic [6:0]         second_slot;
    logic [6:0]         second_orbital;
    logic               last;
    logic               out_of_range;
  } res_t;

endpackage

// File: hw/rtl/cidd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cidd_if
// Channel interfaces: index input, result output and configuration writes.
// ----------------------------------------------------------------------------
interface cidd_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] config_index;
  modport source (output valid, output config_index, input ready);
  modport sink (input valid, input config_index, output ready);
endinterface

interface cidd_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic signed [15:0] coefficient;
  logic [1:0]         change_count;
  logic [6:0]         first_slot;
  logic [6:0]         first_orbital;
  logic [6:0]         second_slot;
  logic [6:0]         second_orbital;
  logic               last;
  logic               out_of_range;
  modport source (output valid, output kind, output coefficient, output change_count,
                  output first_slot, output first_orbital, output second_slot,
                  output second_orbital, output last, output out_of_range, input ready);
  modport sink (input valid, input kind, input coefficient, input change_count,
                input first_slot, input first_orbital, input second_slot,
                input second_orbital, input last, input out_of_range, output ready);
endinterface

interface cidd_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [6:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/cidd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cidd_front
// Accepts an index, builds the class bounds and classifies the index.
// ----------------------------------------------------------------------------
module cidd_front #(
  parameter int MAX_ORBITALS = cidd_pkg::MAX_ORBITALS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  cidd_pkg::cfg_t cfg,
  cidd_in_if.sink        in_ch,
  output logic           push,
  output cidd_pkg::job_t job,
  input  logic           full
);
  import cidd_pkg::*;

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_P    = 3'd1;
  localparam logic [2:0] F_M    = 3'd2;
  localparam logic [2:0] F_G1   = 3'd3;
  localparam logic [2:0] F_G2   = 3'd4;
  localparam logic [2:0] F_PUSH = 3'd5;
  localparam logic [6:0] HI_CAP = 7'(MAX_ORBITALS - 1);

  logic [2:0]  st_r, st_nxt;
  logic [19:0] idx_r;
  logic [10:0] p1_r, p2_r;
  logic [11:0] g3_r;
  logic [16:0] m4_r, m5_r;
  logic [21:0] m6_r;
  logic [23:0] g4_r, g5_r, g6_r, g7_r;

  logic [5:0]  occ, la, hic, omo, umo;
  logic [7:0]  omo_w, umo_w;
  logic        empty;
  logic [11:0] pr1, pr2;
  logic [23:0] idx24, g4_c, g6_c;

  // active window
  always_comb begin
    occ   = cfg.electron_count[6:1];
    la    = cfg.lowest_active;
    hic   = ({1'b0, cfg.highest_active} > HI_CAP) ? HI_CAP[5:0] : cfg.highest_active;
    omo_w = {2'b0, occ} - {2'b0, la};
    umo_w = {2'b0, hic} - {2'b0, occ} + 8'd1;
    empty = omo_w[7] || (omo_w == 8'd0) || umo_w[7] || (umo_w == 8'd0);
    omo   = empty ? 6'd0 : omo_w[5:0];
    umo   = empty ? 6'd0 : umo_w[5:0];
    pr1   = {6'd0, umo} * {6'd0, 6'(umo - 6'd1)};
    pr2   = {6'd0, omo} * {6'd0, 6'(omo - 6'd1)};
    idx24 = {4'd0, idx_r};
    g4_c  = {12'd0, g3_r} + {7'd0, m4_r};
    g6_c  = g5_r + {2'd0, m6_r};
  end

  // classification
  always_comb begin
    job.occ     = occ;
    job.la      = la;
    job.omo     = omo;
    job.umo     = umo;
    job.oor     = 1'b0;
    job.kind    = KIND_GROUND;
    job.n       = 20'd0;
    job.divisor = {5'd0, umo};
    if (idx_r == 20'd0) begin
      job.kind = KIND_GROUND;
    end else if (idx24 > g7_r) begin
      job.oor = 1'b1;
    end else if (idx24 <= {12'd0, g3_r}) begin
      job.kind = KIND_AA_RR;
      job.n    = idx_r - 20'd1;
    end else if (idx24 <= g4_r) begin
      job.kind    = KIND_AA_RS;
      job.n       = 20'(idx24 - {12'd0, g3_r} - 24'd1);
      job.divisor = {5'd0, omo};
    end else if (idx24 <= g5_r) begin
      job.kind = KIND_AB_RR;
      job.n    = 20'(idx24 - g4_r - 24'd1);
    end else if (idx24 <= g6_r) begin
      job.kind    = KIND_AB_RS_A;
      job.n       = 20'(idx24 - g5_r - 24'd1);
      job.divisor = p1_r;
    end else begin
      job.kind    = KIND_AB_RS_B;
      job.n       = 20'(idx24 - g6_r - 24'd1);
      job.divisor = p1_r;
    end
  end

  assign in_ch.ready = (st_r == F_IDLE);
  assign push        = (st_r == F_PUSH) && !full;

  // sequencer
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      F_IDLE: if (in_ch.valid) st_nxt = F_P;
      F_P:    st_nxt = F_M;
      F_M:    st_nxt = F_G1;
      F_G1:   st_nxt = F_G2;
      F_G2:   st_nxt = F_PUSH;
      F_PUSH: if (!full) st_nxt = F_IDLE;
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= F_IDLE;
    else        st_r <= st_nxt;
  end

  // bound datapath
  always_ff @(posedge clk) begin
    if (st_r == F_IDLE && in_ch.valid) idx_r <= in_ch.config_index;
    if (st_r == F_P) begin
      p1_r <= pr1[11:1];
      p2_r <= pr2[11:1];
      g3_r <= {6'd0, omo} * {6'd0, umo};
    end
    if (st_r == F_M) begin
      m4_r <= {11'd0, omo} * {6'd0, p1_r};
      m5_r <= {6'd0, p2_r} * {11'd0, umo};
      m6_r <= {11'd0, p1_r} * {11'd0, p2_r};
    end
    if (st_r == F_G1) begin
      g4_r <= g4_c;
      g5_r <= g4_c + {7'd0, m5_r};
    end
    if (st_r == F_G2) begin
      g6_r <= g6_c;
      g7_r <= g6_c + {2'd0, m6_r};
    end
  end

endmodule

// File: hw/rtl/cidd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cidd_fifo
// Two-entry queue of work words between front and back.
// ----------------------------------------------------------------------------
module cidd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cidd_pkg::job_t wdata,
  output logic           full,
  input  logic           pop,
  output cidd_pkg::job_t rdata,
  output logic           empty
);
  import cidd_pkg::*;

  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rp_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

endmodule

// File: hw/rtl/cidd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cidd_back
// Divides, unranks the orbital pairs and emits the determinant words.
// ----------------------------------------------------------------------------
module cidd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  cidd_pkg::job_t qdata,
  input  logic           qempty,
  output logic           pop,
  output logic           res_valid,
  output cidd_pkg::res_t res,
  input  logic           res_ready
);
  import cidd_pkg::*;

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_DIV  = 3'd1;
  localparam logic [2:0] B_UA   = 3'd2;
  localparam logic [2:0] B_UV   = 3'd3;
  localparam logic [2:0] B_EMIT = 3'd4;

  logic [2:0]  st_r;
  job_t        job_r;
  logic [19:0] qn_r;
  logic [10:0] rm_r, l_r;
  logic [4:0]  dcnt_r;
  logic [19:0] ur_rem_r;
  logic [5:0]  ur_sub_r, ur_cnt_r;
  logic [5:0]  a_r, b_r, r_r, s_r;
  logic [2:0]  j_r;

  logic [11:0] dt;
  logic        dbit;
  logic [19:0] q_nxt;
  logic [10:0] rm_nxt;
  logic        ur_go, slot_free;
  logic [5:0]  ua_a, ua_b, uv_r, uv_s;
  res_t        cur;
  logic [6:0]  a0, a1, b0, b1, r0, r1, s0, s1;

  function automatic res_t rec(input logic [2:0] k, input logic signed [15:0] c,
                               input logic [6:0] sl1, input logic [6:0] or1,
                               input logic [6:0] sl2, input logic [6:0] or2,
                               input logic lst);
    res_t t;
    t.kind = k; t.coefficient = c; t.change_count = 2'd2;
    t.first_slot = sl1; t.first_orbital = or1;
    t.second_slot = sl2; t.second_orbital = or2;
    t.last = lst; t.out_of_range = 1'b0;
    return t;
  endfunction

  // restoring divide step
  always_comb begin
    dt     = {rm_r, qn_r[19]};
    dbit   = (dt >= {1'b0, job_r.divisor});
    rm_nxt = dbit ? 11'(dt - {1'b0, job_r.divisor}) : dt[10:0];
    q_nxt  = {qn_r[18:0], dbit};
  end

  // pair unrank step and its results
  always_comb begin
    ur_go = (ur_sub_r != 6'd0) && (ur_rem_r >= {14'd0, ur_sub_r});
    ua_a  = 6'(ur_cnt_r + job_r.la);
    ua_b  = 6'(ur_rem_r[5:0] + ua_a + 6'd1);
    uv_r  = 6'(ur_cnt_r + job_r.occ);
    uv_s  = 6'(ur_rem_r[5:0] + uv_r + 6'd1);
  end

  // determinant table
  always_comb begin
    a0 = {a_r, 1'b0}; a1 = {a_r, 1'b1};
    b0 = {b_r, 1'b0}; b1 = {b_r, 1'b1};
    r0 = {r_r, 1'b0}; r1 = {r_r, 1'b1};
    s0 = {s_r, 1'b0}; s1 = {s_r, 1'b1};
    cur = '0;
    cur.last = 1'b1;
    case (job_r.kind)
      KIND_AA_RR: cur = rec(KIND_AA_RR, C_ONE, a0, r0, a1, r1, 1'b1);
      KIND_AA_RS: begin
        if (j_r == 3'd0) cur = rec(KIND_AA_RS, C_RT2, a0, r0, a1, s1, 1'b0);
        else             cur = rec(KIND_AA_RS, C_RT2, a0, s0, a1, r1, 1'b1);
      end
      KIND_AB_RR: begin
        if (j_r == 3'd0) cur = rec(KIND_AB_RR, C_RT2, a1, r1, b0, r0, 1'b0);
        else             cur = rec(KIND_AB_RR, C_RT2, a0, r0, b1, r1, 1'b1);
      end
      KIND_AB_RS_A: begin
        case (j_r)
          3'd0: cur = rec(KIND_AB_RS_A, C_TWO12, a0, r0, b0, s0, 1'b0);
          3'd1: cur = rec(KIND_AB_RS_A, C_TWO12, a1, r1, b1, s1, 1'b0);
          3'd2: cur = rec(KIND_AB_RS_A, -C_ONE12, a1, s1, b0, r0, 1'b0);
          3'd3: cur = rec(KIND_AB_RS_A, C_ONE12, a1, r1, b0, s0, 1'b0);
          3'd4: cur = rec(KIND_AB_RS_A, C_ONE12, a0, r0, b1, s1, 1'b0);
          default: cur = rec(KIND_AB_RS_A, -C_ONE12, a0, s0, b1, r1, 1'b1);
        endcase
      end
      KIND_AB_RS_B: begin
        case (j_r)
          3'd0: cur = rec(KIND_AB_RS_B, C_HALF, a1, s1, b0, r0, 1'b0);
          3'd1: cur = rec(KIND_AB_RS_B, C_HALF, a1, r1, b0, s0, 1'b0);
          3'd2: cur = rec(KIND_AB_RS_B, C_HALF, a0, r0, b1, s1, 1'b0);
          default: cur = rec(KIND_AB_RS_B, C_HALF, a0, s0, b1, r1, 1'b1);
        endcase
      end
      default: begin
        cur.kind         = KIND_GROUND;
        cur.coefficient  = job_r.oor ? 16'sd0 : C_ONE;
        cur.out_of_range = job_r.oor;
      end
    endcase
  end

  assign slot_free = !res_valid || res_ready;
  assign pop       = (st_r == B_IDLE) && !qempty;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= B_IDLE;
      res_valid <= 1'b0;
      j_r       <= 3'd0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      case (st_r)
        B_IDLE: begin
          j_r <= 3'd0;
          if (!qempty) st_r <= (qdata.kind == KIND_GROUND) ? B_EMIT : B_DIV;
        end
        B_DIV: begin
          if (dcnt_r == 5'd19) begin
            if (job_r.kind == KIND_AA_RR)      st_r <= B_EMIT;
            else if (job_r.kind == KIND_AA_RS) st_r <= B_UV;
            else                               st_r <= B_UA;
          end
        end
        B_UA: if (!ur_go) st_r <= (job_r.kind == KIND_AB_RR) ? B_EMIT : B_UV;
        B_UV: if (!ur_go) st_r <= B_EMIT;
        B_EMIT: begin
          if (slot_free) begin
            res_valid <= 1'b1;
            j_r       <= j_r + 3'd1;
            if (cur.last) st_r <= B_IDLE;
          end
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (st_r)
      B_IDLE: begin
        job_r  <= qdata;
        qn_r   <= qdata.n;
        rm_r   <= 11'd0;
        dcnt_r <= 5'd0;
      end
      B_DIV: begin
        qn_r   <= q_nxt;
        rm_r   <= rm_nxt;
        dcnt_r <= dcnt_r + 5'd1;
        if (dcnt_r == 5'd19) begin
          l_r      <= rm_nxt;
          ur_cnt_r <= 6'd0;
          ur_rem_r <= q_nxt;
          if (job_r.kind == KIND_AA_RR) begin
            a_r <= 6'(q_nxt[5:0] + job_r.la);
            r_r <= 6'(rm_nxt[5:0] + job_r.occ);
          end else if (job_r.kind == KIND_AA_RS) begin
            a_r      <= 6'(rm_nxt[5:0] + job_r.la);
            ur_sub_r <= 6'(job_r.umo - 6'd1);
          end else begin
            r_r      <= 6'(rm_nxt[5:0] + job_r.occ);
            ur_sub_r <= 6'(job_r.omo - 6'd1);
          end
        end
      end
      B_UA: begin
        if (ur_go) begin
          ur_rem_r <= ur_rem_r - {14'd0, ur_sub_r};
          ur_sub_r <= ur_sub_r - 6'd1;
          ur_cnt_r <= ur_cnt_r + 6'd1;
        end else begin
          a_r      <= ua_a;
          b_r      <= ua_b;
          ur_rem_r <= {9'd0, l_r};
          ur_sub_r <= 6'(job_r.umo - 6'd1);
          ur_cnt_r <= 6'd0;
        end
      end
      B_UV: begin
        if (ur_go) begin
          ur_rem_r <= ur_rem_r - {14'd0, ur_sub_r};
          ur_sub_r <= ur_sub_r - 6'd1;
          ur_cnt_r <= ur_cnt_r + 6'd1;
        end else begin
          r_r <= uv_r;
          s_r <= uv_s;
        end
      end
      B_EMIT: if (slot_free) res <= cur;
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/ci_doubles_index_to_determinants.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ci_doubles_index_to_determinants
// Decodes a doubles configuration index into its determinant words.
// ----------------------------------------------------------------------------
// flow: an accepted index passes front states P, M, G1 and G2 to the queue push,
//   which waits while the queue is full, and is popped by the back; excited classes
//   then run a restoring divide and up to two pair unrank loops of one step a cycle,
//   then one determinant word per cycle while the output is ready; the front takes
//   no new index until its word is pushed, the back pops only after its last word
// reset: synchronous active-low, registers return to 2/0/1, queue empties
module ci_doubles_index_to_determinants #(
  parameter int MAX_ORBITALS = cidd_pkg::MAX_ORBITALS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  cidd_in_if.sink    in_ch,
  cidd_out_if.source out_ch,
  cidd_cfg_if.sink   cfg_ch
);
  import cidd_pkg::*;

  cfg_t cfg_r;
  job_t f_job, q_job;
  res_t res;
  logic q_push, q_full, q_pop, q_empty, res_valid;

  // configuration registers
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.electron_count <= 7'd2;
      cfg_r.lowest_active  <= 6'd0;
      cfg_r.highest_active <= 6'd1;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_ELECTRON_COUNT: cfg_r.electron_count <= cfg_ch.data;
        CFG_LOWEST_ACTIVE:  cfg_r.lowest_active  <= cfg_ch.data[5:0];
        CFG_HIGHEST_ACTIVE: cfg_r.highest_active <= cfg_ch.data[5:0];
        default: ;
      endcase
    end
  end

  cidd_front #(.MAX_ORBITALS(MAX_ORBITALS)) u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .in_ch(in_ch),
    .push(q_push), .job(f_job), .full(q_full)
  );

  cidd_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(q_push), .wdata(f_job), .full(q_full),
    .pop(q_pop), .rdata(q_job), .empty(q_empty)
  );

  cidd_back u_back (
    .clk(clk), .rst_n(rst_n), .qdata(q_job), .qempty(q_empty), .pop(q_pop),
    .res_valid(res_valid), .res(res), .res_ready(out_ch.ready)
  );

  // result word
  assign out_ch.valid          = res_valid;
  assign out_ch.kind           = res.kind;
  assign out_ch.coefficient    = res.coefficient;
  assign out_ch.change_count   = res.change_count;
  assign out_ch.first_slot     = res.first_slot;
  assign out_ch.first_orbital  = res.first_orbital;
  assign out_ch.second_slot    = res.second_slot;
  assign out_ch.second_orbital = res.second_orbital;
  assign out_ch.last           = res.last;
  assign out_ch.out_of_range   = res.out_of_range;

  // checks
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("queue overflow");
  a_oor_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.out_of_range) |-> out_ch.last) else $error("oor not last");
  a_ground_noswap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.change_count == 2'd0) |-> (out_ch.kind == KIND_GROUND))
    else $error("unchanged word not ground");
  a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready) else $error("front took two words");

endmodule

// File: test/ci_doubles_index_to_determinants_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ci_doubles_index_to_determinants_tb
// Drives configuration indexes through the doubles decoder under several
// orbital windows, predicts every determinant word and checks each one in
// order, with random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module ci_doubles_index_to_determinants_tb;
  import cidd_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_cnt = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  cidd_in_if  in_ch ();
  cidd_out_if out_ch ();
  cidd_cfg_if cfg_ch ();

  ci_doubles_index_to_determinants dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // decoder settings mirrored in the testbench
  int unsigned n_elec = 2, lo_act = 0, hi_act = 1;

  res_t det_q[$];
  bit   calm = 1'b0;
  bit   hold_off = 1'b0;

  // class bounds of the current window
  function automatic void class_bounds(output int occ, omo, umo, p1, p2,
                                       g3, g4, g5, g6, g7);
    int hi;
    occ = n_elec >> 1;
    hi = (hi_act > 63) ? 63 : hi_act;
    omo = occ - int'(lo_act);
    umo = hi - occ + 1;
    if (omo < 1 || umo < 1) begin
      omo = 0;
      umo = 0;
    end
    p1 = umo * (umo - 1) / 2;
    p2 = omo * (omo - 1) / 2;
    g3 = omo * umo;
    g4 = g3 + omo * p1;
    g5 = g4 + p2 * umo;
    g6 = g5 + p1 * p2;
    g7 = g6 + p1 * p2;
  endfunction

  function automatic int pair_first(inout int rem, input int n);
    int sub, cnt;
    sub = n - 1;
    cnt = 0;
    while (sub > 0 && rem >= sub) begin
      rem -= sub;
      sub--;
      cnt++;
    end
    return cnt;
  endfunction

  function automatic res_t det_word(logic [2:0] kd, logic signed [15:0] cf,
                                    int s1, int o1, int s2, int o2, bit lst);
    res_t w;
    w.kind = kd;
    w.coefficient = cf;
    w.change_count = 2'd2;
    w.first_slot = s1[6:0];
    w.first_orbital = o1[6:0];
    w.second_slot = s2[6:0];
    w.second_orbital = o2[6:0];
    w.last = lst;
    w.out_of_range = 1'b0;
    return w;
  endfunction

  // queue every determinant word that one index decodes into
  task automatic predict_dets(int idx);
    int occ, omo, umo, p1, p2, g3, g4, g5, g6, g7;
    int a, b, r, s, k, l, n;
    res_t w;
    class_bounds(occ, omo, umo, p1, p2, g3, g4, g5, g6, g7);
    w = '0;
    w.last = 1'b1;
    if (idx == 0) begin
      w.kind = KIND_GROUND;
      w.coefficient = C_ONE;
      det_q.push_back(w);
    end else if (idx > g7) begin
      w.out_of_range = 1'b1;
      det_q.push_back(w);
    end else if (idx <= g3) begin
      n = idx - 1;
      r = n % umo + occ;
      a = n / umo + int'(lo_act);
      det_q.push_back(det_word(KIND_AA_RR, C_ONE, 2*a, 2*r, 2*a+1, 2*r+1, 1));
    end else if (idx <= g4) begin
      n = idx - g3 - 1;
      a = n % omo + int'(lo_act);
      l = n / omo;
      r = pair_first(l, umo) + occ;
      s = l + r + 1;
      det_q.push_back(det_word(KIND_AA_RS, C_RT2, 2*a, 2*r, 2*a+1, 2*s+1, 0));
      det_q.push_back(det_word(KIND_AA_RS, C_RT2, 2*a, 2*s, 2*a+1, 2*r+1, 1));
    end else if (idx <= g5) begin
      n = idx - g4 - 1;
      r = n % umo + occ;
      k = n / umo;
      a = pair_first(k, omo) + int'(lo_act);
      b = k + a + 1;
      det_q.push_back(det_word(KIND_AB_RR, C_RT2, 2*a+1, 2*r+1, 2*b, 2*r, 0));
      det_q.push_back(det_word(KIND_AB_RR, C_RT2, 2*a, 2*r, 2*b+1, 2*r+1, 1));
    end else begin
      n = (idx <= g6) ? idx - g5 - 1 : idx - g6 - 1;
      l = n % p1;
      k = n / p1;
      a = pair_first(k, omo) + int'(lo_act);
      b = k + a + 1;
      r = pair_first(l, umo) + occ;
      s = l + r + 1;
      if (idx <= g6) begin
        det_q.push_back(det_word(KIND_AB_RS_A, C_TWO12, 2*a, 2*r, 2*b, 2*s, 0));
        det_q.push_back(det_word(KIND_AB_RS_A, C_TWO12, 2*a+1, 2*r+1, 2*b+1, 2*s+1, 0));
        det_q.push_back(det_word(KIND_AB_RS_A, -C_ONE12, 2*a+1, 2*s+1, 2*b, 2*r, 0));
        det_q.push_back(det_word(KIND_AB_RS_A, C_ONE12, 2*a+1, 2*r+1, 2*b, 2*s, 0));
        det_q.push_back(det_word(KIND_AB_RS_A, C_ONE12, 2*a, 2*r, 2*b+1, 2*s+1, 0));
        det_q.push_back(det_word(KIND_AB_RS_A, -C_ONE12, 2*a, 2*s, 2*b+1, 2*r+1, 1));
      end else begin
        det_q.push_back(det_word(KIND_AB_RS_B, C_HALF, 2*a+1, 2*s+1, 2*b, 2*r, 0));
        det_q.push_back(det_word(KIND_AB_RS_B, C_HALF, 2*a+1, 2*r+1, 2*b, 2*s, 0));
        det_q.push_back(det_word(KIND_AB_RS_B, C_HALF, 2*a, 2*r, 2*b+1, 2*s+1, 0));
        det_q.push_back(det_word(KIND_AB_RS_B, C_HALF, 2*a, 2*s, 2*b+1, 2*r+1, 1));
      end
    end
  endtask

  // one register write through the config channel, valid left up
  task automatic write_reg(logic [1:0] ridx, logic [6:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= ridx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (ridx)
      CFG_ELECTRON_COUNT: n_elec = val;
      CFG_LOWEST_ACTIVE:  lo_act = val[5:0];
      default:            hi_act = val[5:0];
    endcase
  endtask

  task automatic set_window(int ne, int la, int ha);
    write_reg(CFG_ELECTRON_COUNT, ne[6:0]);
    write_reg(CFG_LOWEST_ACTIVE, la[6:0]);
    write_reg(CFG_HIGHEST_ACTIVE, ha[6:0]);
    cfg_ch.valid <= 1'b0;
  endtask

  // send one index word, at times with a random gap in front of it
  task automatic send_index(logic [19:0] idx);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.config_index <= idx;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_dets(idx);
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    while (det_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic int total_configs;
    int occ, omo, umo, p1, p2, g3, g4, g5, g6, g7;
    class_bounds(occ, omo, umo, p1, p2, g3, g4, g5, g6, g7);
    return g7;
  endfunction

  // random index: mostly in range, some past the end
  function automatic logic [19:0] rand_index;
    int g7;
    g7 = total_configs();
    case ($urandom_range(0, 9))
      0: return 20'($urandom);
      1: return 20'(g7 + 1);
      2: return 20'(g7);
      default: return 20'($urandom_range(0, g7));
    endcase
  endfunction

  // directed table: the checked words come from the predictor
  logic [19:0] dir_tab[12] = '{20'd0, 20'd1, 20'd2, 20'd3, 20'd4, 20'd5,
                               20'd6, 20'd7, 20'd8, 20'd9, 20'd10, 20'hFFFFF};

  // stimulus
  initial begin
    int unsigned ne, la, ha;
    in_ch.valid = 1'b0;
    in_ch.config_index = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_ELECTRON_COUNT;
    cfg_ch.data = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset window: ground, one aa_rr, then past the end
    send_index(20'd0);
    send_index(20'd1);
    send_index(20'd2);
    drain();

    // small window: ground, both aa classes, the last ab_rs_b index and past the end
    set_window(6, 1, 5);
    foreach (dir_tab[i]) send_index(dir_tab[i]);
    send_index(20'(total_configs()));
    send_index(20'(total_configs() + 1));
    drain();

    // empty window and odd electron count
    set_window(7, 3, 2);
    send_index(20'd0);
    send_index(20'd1);
    drain();

    // extremes of the registers
    set_window(126, 63, 63);
    send_index(20'd1);
    send_index(20'd5);
    drain();
    set_window(126, 0, 63);
    send_index(20'hFFFFF);
    send_index(20'h80000);
    send_index(20'h7FFFF);
    drain();

    // long hold-off on the result side while indexes keep coming
    set_window(8, 0, 7);
    hold_off = 1'b1;
    repeat (10) send_index(rand_index());
    hold_off = 1'b0;
    drain();

    // random windows with random indexes
    for (int ph = 0; ph < 8; ph++) begin
      ne = 2 * $urandom_range(1, 20);
      la = $urandom_range(0, ne / 2 - 1);
      ha = $urandom_range(ne / 2, (ph == 0) ? 63 : ne / 2 + 8);
      if (ph == 7) calm = 1'b1;
      set_window(ne, la, ha);
      repeat (8) send_index(rand_index());
      drain();
    end

    if (fail_cnt == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  // result side ready with random stalls and one long hold-off
  initial begin
    int stall, held;
    out_ch.ready = 1'b0;
    held = 0;
    forever begin
      @(posedge clk);
      if (hold_off && held < 400) begin
        held++;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        stall = $urandom_range(1, 17);
        repeat (stall - 1) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // compare each accepted word with the oldest prediction
  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (det_q.size() == 0) begin
        $error("unexpected result word");
        fail_cnt++;
      end else begin
        e = det_q.pop_front();
        if (out_ch.kind !== e.kind) begin
          $error("kind exp %0d got %0d", e.kind, out_ch.kind); fail_cnt++;
        end
        if (out_ch.coefficient !== e.coefficient) begin
          $error("coefficient exp %0d got %0d", e.coefficient, out_ch.coefficient);
          fail_cnt++;
        end
        if (out_ch.change_count !== e.change_count) begin
          $error("change_count exp %0d got %0d", e.change_count, out_ch.change_count);
          fail_cnt++;
        end
        if (out_ch.first_slot !== e.first_slot) begin
          $error("first_slot exp %0d got %0d", e.first_slot, out_ch.first_slot);
          fail_cnt++;
        end
        if (out_ch.first_orbital !== e.first_orbital) begin
          $error("first_orbital exp %0d got %0d", e.first_orbital, out_ch.first_orbital);
          fail_cnt++;
        end
        if (out_ch.second_slot !== e.second_slot) begin
          $error("second_slot exp %0d got %0d", e.second_slot, out_ch.second_slot);
          fail_cnt++;
        end
        if (out_ch.second_orbital !== e.second_orbital) begin
          $error("second_orbital exp %0d got %0d", e.second_orbital,
                 out_ch.second_orbital);
          fail_cnt++;
        end
        if (out_ch.last !== e.last) begin
          $error("last exp %0d got %0d", e.last, out_ch.last); fail_cnt++;
        end
        if (out_ch.out_of_range !== e.out_of_range) begin
          $error("out_of_range exp %0d got %0d", e.out_of_range, out_ch.out_of_range);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
